/* rtl/pnz_pkg.sv */
package pnz_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int AW          = $clog2(TABLE_DEPTH);
    localparam int FRAC_BITS   = 16;
    localparam int COORD_W     = FRAC_BITS + 8;

    localparam int T_W   = FRAC_BITS + 2;
    localparam int P_W   = FRAC_BITS + 8;
    localparam int G_W   = FRAC_BITS + 8;
    localparam int D_W   = G_W + 1;
    localparam int X_W   = G_W + 1;
    localparam int D2_W  = X_W + 1;
    localparam int PR_W  = T_W + D2_W;
    localparam int OUT_W = 18;

    localparam int OUT_SH = FRAC_BITS + 5 - 16;
    localparam int RSH    = (OUT_SH > 0) ? OUT_SH : 0;
    localparam int LSH    = (OUT_SH < 0) ? -OUT_SH : 0;

    localparam int FIFO_DEPTH = 16;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int LAT        = 10;

    typedef enum logic
    {
        CMD_LOAD = 1'b0,
        CMD_EVAL = 1'b1
    } cmd_t;

    typedef enum logic [1:0]
    {
        SIDE_POS_X = 2'd0,
        SIDE_POS_Y = 2'd1,
        SIDE_NEG_X = 2'd2,
        SIDE_NEG_Y = 2'd3
    } side_t;

    function automatic logic [AW-1:0] tidx(input logic [8:0] s);
        logic [AW+8:0] w;
        w = {{AW{1'b0}}, s};
        return w[AW-1:0];
    endfunction

    // renormalise by FRAC_BITS, round half up
    function automatic logic signed [PR_W-1:0] rnd(input logic signed [PR_W-1:0] v);
        logic signed [PR_W-1:0] half;
        half = PR_W'(64'sd1 <<< (FRAC_BITS - 1));
        return (v + half) >>> FRAC_BITS;
    endfunction

endpackage

/* rtl/pnz_hash.sv */
module pnz_hash
(
    input  logic                    clk,
    input  logic                    load,
    input  logic [7:0]              load_index,
    input  logic [7:0]              load_value,
    input  logic [7:0]              x_int,
    input  logic [7:0]              y_int,
    output logic [7:0]              h00,
    output logic [7:0]              h01,
    output logic [7:0]              h10,
    output logic [7:0]              h11
);
    import pnz_pkg::*;

    logic [7:0] mem_a [TABLE_DEPTH];
    logic [7:0] mem_b [TABLE_DEPTH];
    logic [7:0] mem_c [TABLE_DEPTH];

    logic [7:0]    ha_reg, hb_reg, yi_reg;
    logic [7:0]    h00_reg, h01_reg, h10_reg, h11_reg;
    logic [AW-1:0] wr_addr, xa0, xa1, b0, b1, c0, c1;

    always_comb
    begin
        wr_addr = tidx({1'b0, load_index});
        xa0     = tidx({1'b0, x_int});
        xa1     = tidx({1'b0, x_int} + 9'd1);
        b0      = tidx({1'b0, ha_reg} + {1'b0, yi_reg});
        b1      = tidx({1'b0, ha_reg} + {1'b0, yi_reg} + 9'd1);
        c0      = tidx({1'b0, hb_reg} + {1'b0, yi_reg});
        c1      = tidx({1'b0, hb_reg} + {1'b0, yi_reg} + 9'd1);
    end

    // three copies written together, so each copy serves only two reads
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            mem_a[wr_addr] <= load_value;
            mem_b[wr_addr] <= load_value;
            mem_c[wr_addr] <= load_value;
        end
        ha_reg  <= mem_a[xa0];
        hb_reg  <= mem_a[xa1];
        yi_reg  <= y_int;
        h00_reg <= mem_b[b0];
        h01_reg <= mem_b[b1];
        h10_reg <= mem_c[c0];
        h11_reg <= mem_c[c1];
    end

    assign h00 = h00_reg;
    assign h01 = h01_reg;
    assign h10 = h10_reg;
    assign h11 = h11_reg;

endmodule

/* rtl/pnz_fade.sv */
module pnz_fade
(
    input  logic                              clk,
    input  logic [pnz_pkg::FRAC_BITS-1:0]     t,
    output logic signed [pnz_pkg::T_W-1:0]    fade
);
    import pnz_pkg::*;

    logic signed [T_W-1:0]  ts, t1_reg, t2_reg, t3_reg, fade_reg;
    logic signed [P_W-1:0]  p0, p1, p2, p3;
    logic signed [PR_W-1:0] m1_reg, m2_reg, m3_reg, m4_reg;
    logic signed [PR_W-1:0] m1_next, m2_next, m3_next, m4_next;

    always_comb
    begin
        ts      = signed'({2'b00, t});
        p0      = (P_W'(ts) <<< 2) + (P_W'(ts) <<< 1) - P_W'(64'sd15 <<< FRAC_BITS);
        m1_next = PR_W'(ts) * PR_W'(p0);
        p1      = P_W'(rnd(m1_reg)) + P_W'(64'sd10 <<< FRAC_BITS);
        m2_next = PR_W'(t1_reg) * PR_W'(p1);
        p2      = P_W'(rnd(m2_reg));
        m3_next = PR_W'(t2_reg) * PR_W'(p2);
        p3      = P_W'(rnd(m3_reg));
        m4_next = PR_W'(t3_reg) * PR_W'(p3);
    end

    always_ff @(posedge clk)
    begin
        t1_reg   <= ts;
        t2_reg   <= t1_reg;
        t3_reg   <= t2_reg;
        m1_reg   <= m1_next;
        m2_reg   <= m2_next;
        m3_reg   <= m3_next;
        m4_reg   <= m4_next;
        fade_reg <= T_W'(rnd(m4_reg));
    end

    assign fade = fade_reg;

endmodule

/* rtl/pnz_blend.sv */
module pnz_blend
(
    input  logic                              clk,
    input  logic [7:0]                        h00,
    input  logic [7:0]                        h01,
    input  logic [7:0]                        h10,
    input  logic [7:0]                        h11,
    input  logic [pnz_pkg::FRAC_BITS-1:0]     dx,
    input  logic [pnz_pkg::FRAC_BITS-1:0]     dy,
    input  logic signed [pnz_pkg::T_W-1:0]    u,
    input  logic signed [pnz_pkg::T_W-1:0]    v,
    output logic signed [pnz_pkg::OUT_W-1:0]  noise
);
    import pnz_pkg::*;

    function automatic logic signed [G_W-1:0] grad(input logic [7:0] h,
                                                   input logic signed [T_W-1:0] x,
                                                   input logic signed [T_W-1:0] y);
        logic signed [6:0]     dd;
        logic signed [G_W-1:0] xs, ys, r;
        dd = signed'({1'b0, h[5:0]}) - 7'sd32;
        xs = G_W'(x);
        ys = G_W'(y);
        unique case (side_t'(h[7:6]))
            SIDE_POS_X: r = (xs <<< 5) + G_W'(dd) * ys;
            SIDE_POS_Y: r = G_W'(dd) * xs + (ys <<< 5);
            SIDE_NEG_X: r = G_W'(dd) * ys - (xs <<< 5);
            SIDE_NEG_Y: r = G_W'(dd) * xs - (ys <<< 5);
        endcase
        return r;
    endfunction

    localparam logic signed [T_W-1:0]  ONE    = T_W'(64'sd1 <<< FRAC_BITS);
    localparam logic signed [PR_W-1:0] RND_C  = PR_W'((RSH > 0) ? (64'sd1 <<< (RSH - 1)) : 64'sd0);
    localparam logic signed [PR_W-1:0] SAT_HI = PR_W'(131071);
    localparam logic signed [PR_W-1:0] SAT_LO = -PR_W'(131072);

    logic signed [T_W-1:0]   xp, xm, yp, ym;
    logic signed [G_W-1:0]   g00_reg, g01_reg, g10_reg, g11_reg;
    logic signed [G_W-1:0]   a0_reg, a1_reg, a0p_reg, a1p_reg, a0q_reg, a1q_reg;
    logic signed [D_W-1:0]   df0_reg, df1_reg, df0p_reg, df1p_reg;
    logic signed [PR_W-1:0]  pr0_reg, pr1_reg, pr2_reg;
    logic signed [X_W-1:0]   x1_reg, x2_reg, x1b_reg, x1c_reg;
    logic signed [D2_W-1:0]  dd2_reg;
    logic signed [T_W-1:0]   v6_reg, v7_reg, v8_reg;
    logic signed [PR_W-1:0]  r_w, adj;
    logic signed [OUT_W-1:0] noise_reg, noise_next;

    always_comb
    begin
        xp = signed'({2'b00, dx});
        yp = signed'({2'b00, dy});
        xm = xp - ONE;
        ym = yp - ONE;
        r_w = PR_W'(x1c_reg) + rnd(pr2_reg);
        adj = ((r_w + RND_C) >>> RSH) <<< LSH;
        if (adj > SAT_HI)
            noise_next = OUT_W'(SAT_HI);
        else if (adj < SAT_LO)
            noise_next = OUT_W'(SAT_LO);
        else
            noise_next = OUT_W'(adj);
    end

    always_ff @(posedge clk)
    begin
        g00_reg  <= grad(h00, xp, yp);
        g10_reg  <= grad(h10, xm, yp);
        g01_reg  <= grad(h01, xp, ym);
        g11_reg  <= grad(h11, xm, ym);
        a0_reg   <= g00_reg;
        a1_reg   <= g01_reg;
        df0_reg  <= D_W'(g10_reg) - D_W'(g00_reg);
        df1_reg  <= D_W'(g11_reg) - D_W'(g01_reg);
        a0p_reg  <= a0_reg;
        a1p_reg  <= a1_reg;
        df0p_reg <= df0_reg;
        df1p_reg <= df1_reg;
        pr0_reg  <= PR_W'(u) * PR_W'(df0p_reg);
        pr1_reg  <= PR_W'(u) * PR_W'(df1p_reg);
        a0q_reg  <= a0p_reg;
        a1q_reg  <= a1p_reg;
        v6_reg   <= v;
        x1_reg   <= X_W'(PR_W'(a0q_reg) + rnd(pr0_reg));
        x2_reg   <= X_W'(PR_W'(a1q_reg) + rnd(pr1_reg));
        v7_reg   <= v6_reg;
        dd2_reg  <= D2_W'(x2_reg) - D2_W'(x1_reg);
        x1b_reg  <= x1_reg;
        v8_reg   <= v7_reg;
        pr2_reg  <= PR_W'(v8_reg) * PR_W'(dd2_reg);
        x1c_reg  <= x1b_reg;
        noise_reg <= noise_next;
    end

    assign noise = noise_reg;

endmodule

/* rtl/pnz_fifo.sv */
module pnz_fifo
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              push,
    input  logic signed [pnz_pkg::OUT_W-1:0]  push_data,
    input  logic                              pop,
    output logic                              valid,
    output logic signed [pnz_pkg::OUT_W-1:0]  data
);
    import pnz_pkg::*;

    logic signed [OUT_W-1:0] slot_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0]      wr_reg, wr_next, rd_reg, rd_next;
    logic [FIFO_AW:0]        cnt_reg, cnt_next;

    always_comb
    begin
        wr_next  = push ? wr_reg + 1'b1 : wr_reg;
        rd_next  = pop ? rd_reg + 1'b1 : rd_reg;
        cnt_next = cnt_reg + (FIFO_AW+1)'(push) - (FIFO_AW+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_reg] <= push_data;
    end

    assign valid = cnt_reg != '0;
    assign data  = slot_reg[rd_reg];

endmodule

/* rtl/perlin_noise_2d.sv */
// channel  | handshake              | fields
// cmd      | cmd_valid / cmd_stall  | command, table_index, table_value, x_coord, y_coord
// noise    | noise_valid / noise_stall | noise_value
//
// One item per cycle while cmd_stall is low. An evaluate result passes through the
// two dependent table reads, the four-multiply fade chain and the two lerp levels.
// Results queue in a 16-entry buffer; cmd_stall rises only when 16 results are in flight.
// Loads give no result. Reset clears control only; the table is undefined until loaded.
module perlin_noise_2d
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cmd_valid,
    output logic                                cmd_stall,
    input  logic                                command,
    input  logic [7:0]                          table_index,
    input  logic [7:0]                          table_value,
    input  logic [pnz_pkg::COORD_W-1:0]         x_coord,
    input  logic [pnz_pkg::COORD_W-1:0]         y_coord,
    output logic                                noise_valid,
    input  logic                                noise_stall,
    output logic signed [pnz_pkg::OUT_W-1:0]    noise_value
);
    import pnz_pkg::*;

    logic                    xfer, eval_acc, load_acc, pop;
    logic [LAT:1]            eval_pipe_reg, eval_pipe_next;
    logic [FIFO_AW:0]        credit_reg, credit_next;
    logic [FRAC_BITS-1:0]    dx1_reg, dx2_reg, dy1_reg, dy2_reg;
    logic [7:0]              h00, h01, h10, h11;
    logic signed [T_W-1:0]   u, v;
    logic signed [OUT_W-1:0] noise;

    always_comb
    begin
        xfer           = cmd_valid && !cmd_stall;
        eval_acc       = xfer && (command == CMD_EVAL);
        load_acc       = xfer && (command == CMD_LOAD);
        pop            = noise_valid && !noise_stall;
        eval_pipe_next = {eval_pipe_reg[LAT-1:1], eval_acc};
        credit_next    = credit_reg + (FIFO_AW+1)'(eval_acc) - (FIFO_AW+1)'(pop);
    end

    assign cmd_stall = credit_reg == (FIFO_AW+1)'(FIFO_DEPTH);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eval_pipe_reg <= '0;
            credit_reg    <= '0;
        end
        else
        begin
            eval_pipe_reg <= eval_pipe_next;
            credit_reg    <= credit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dx1_reg <= x_coord[FRAC_BITS-1:0];
        dy1_reg <= y_coord[FRAC_BITS-1:0];
        dx2_reg <= dx1_reg;
        dy2_reg <= dy1_reg;
    end

    pnz_hash u_hash
    (
        .clk        (clk),
        .load       (load_acc),
        .load_index (table_index),
        .load_value (table_value),
        .x_int      (x_coord[FRAC_BITS+7:FRAC_BITS]),
        .y_int      (y_coord[FRAC_BITS+7:FRAC_BITS]),
        .h00        (h00),
        .h01        (h01),
        .h10        (h10),
        .h11        (h11)
    );

    pnz_fade u_fade_x
    (
        .clk  (clk),
        .t    (x_coord[FRAC_BITS-1:0]),
        .fade (u)
    );

    pnz_fade u_fade_y
    (
        .clk  (clk),
        .t    (y_coord[FRAC_BITS-1:0]),
        .fade (v)
    );

    pnz_blend u_blend
    (
        .clk   (clk),
        .h00   (h00),
        .h01   (h01),
        .h10   (h10),
        .h11   (h11),
        .dx    (dx2_reg),
        .dy    (dy2_reg),
        .u     (u),
        .v     (v),
        .noise (noise)
    );

    pnz_fifo u_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (eval_pipe_reg[LAT]),
        .push_data (noise),
        .pop       (pop),
        .valid     (noise_valid),
        .data      (noise_value)
    );

`ifndef SYNTH
    a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        credit_reg <= (FIFO_AW+1)'(FIFO_DEPTH))
        else $error("credit count above buffer depth");

    a_result_has_credit: assert property (@(posedge clk) disable iff (!rst_n)
        noise_valid |-> credit_reg != '0)
        else $error("result waiting with no credit taken");

    a_eval_takes_credit: assert property (@(posedge clk) disable iff (!rst_n)
        eval_acc |=> credit_reg != '0)
        else $error("evaluate transfer did not take a credit");
`endif

endmodule

/* tb/sv/perlin_noise_2d_tb.sv */
`timescale 1ns / 1ps

module perlin_noise_2d_tb;
    import pnz_pkg::*;

    typedef struct packed
    {
        logic        cmd;
        logic [7:0]  idx;
        logic [7:0]  val;
        logic [23:0] xc;
        logic [23:0] yc;
    } cmd_item_t;

    logic                    clk;
    logic                    rst_n;
    logic                    cmd_valid;
    logic                    cmd_stall;
    logic                    command;
    logic [7:0]              table_index;
    logic [7:0]              table_value;
    logic [COORD_W-1:0]      x_coord;
    logic [COORD_W-1:0]      y_coord;
    logic                    noise_valid;
    logic                    noise_stall;
    logic signed [OUT_W-1:0] noise_value;

    cmd_item_t        pending_cmds[$];
    logic signed [17:0] expected_noise[$];
    logic [7:0]       perm_copy[256];
    int               mismatches;
    int               noise_seen;
    int               loads_sent;
    int               evals_sent;
    int               hold_cycles;
    logic             long_hold;
    logic             stim_done;
    logic             cmd_blocked;

    perlin_noise_2d uut
    (
        .clk(clk),
        .rst_n(rst_n),
        .cmd_valid(cmd_valid),
        .cmd_stall(cmd_stall),
        .command(command),
        .table_index(table_index),
        .table_value(table_value),
        .x_coord(x_coord),
        .y_coord(y_coord),
        .noise_valid(noise_valid),
        .noise_stall(noise_stall),
        .noise_value(noise_value)
    );

    initial clk = 1'b0;
    always #6 clk = ~clk;

    function automatic longint round_shr(input longint v, input int s);
        longint w;
        w = v + (longint'(1) << (s - 1));
        return w >>> s;
    endfunction

    function automatic longint fix_mul(input longint a, input longint b);
        return round_shr(a * b, FRAC_BITS);
    endfunction

    function automatic longint quintic_fade(input longint t);
        longint p;
        p = 6 * t - 15 * (longint'(1) << FRAC_BITS);
        p = fix_mul(t, p) + 10 * (longint'(1) << FRAC_BITS);
        p = fix_mul(t, p);
        p = fix_mul(t, p);
        return fix_mul(t, p);
    endfunction

    function automatic longint corner_dot(input logic [7:0] h, input longint gx,
                                          input longint gy);
        longint d;
        d = longint'(h[5:0]) - 32;
        case (side_t'(h[7:6]))
            SIDE_POS_X: return 32 * gx + d * gy;
            SIDE_POS_Y: return d * gx + 32 * gy;
            SIDE_NEG_X: return -32 * gx + d * gy;
            default:    return d * gx - 32 * gy;
        endcase
    endfunction

    function automatic longint blend(input longint a, input longint b, input longint w);
        return a + fix_mul(w, b - a);
    endfunction

    function automatic logic signed [17:0] noise_at(input logic [23:0] xc,
                                                    input logic [23:0] yc);
        logic [7:0] xi, yi, xi1, yi1, h00, h01, h10, h11;
        longint     dx, dy, u, v, one, x1, x2, r;
        one = longint'(1) << FRAC_BITS;
        xi  = xc[23:16];
        yi  = yc[23:16];
        xi1 = xi + 8'd1;
        yi1 = yi + 8'd1;
        dx  = longint'(xc[15:0]);
        dy  = longint'(yc[15:0]);
        h00 = perm_copy[8'(perm_copy[xi] + yi)];
        h01 = perm_copy[8'(perm_copy[xi] + yi1)];
        h10 = perm_copy[8'(perm_copy[xi1] + yi)];
        h11 = perm_copy[8'(perm_copy[xi1] + yi1)];
        u   = quintic_fade(dx);
        v   = quintic_fade(dy);
        x1  = blend(corner_dot(h00, dx, dy), corner_dot(h10, dx - one, dy), u);
        x2  = blend(corner_dot(h01, dx, dy - one), corner_dot(h11, dx - one, dy - one), u);
        r   = round_shr(blend(x1, x2, v), 5);
        if (r > 131071)
            r = 131071;
        if (r < -131072)
            r = -131072;
        return 18'(r);
    endfunction

    task automatic queue_load(input logic [7:0] i, input logic [7:0] v);
        pending_cmds.push_back('{CMD_LOAD, i, v, 24'($urandom), 24'($urandom)});
    endtask

    task automatic queue_eval(input logic [23:0] xc, input logic [23:0] yc);
        pending_cmds.push_back('{CMD_EVAL, 8'($urandom), 8'($urandom), xc, yc});
    endtask

    task automatic report_mismatch(input logic signed [17:0] got,
                                   input logic signed [17:0] want);
        $display("mismatch: noise_value %0d, expected %0d at %0t", got, want, $time);
        mismatches++;
    endtask

    function automatic int gap_len();
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(10, 40);
        if ($urandom_range(0, 2) == 0)
            return 0;
        return $urandom_range(0, 3);
    endfunction

    // offered item still waiting after the last rising edge
    always @(posedge clk)
        cmd_blocked <= rst_n && cmd_valid && cmd_stall;

    // driver
    int send_gap;
    always @(negedge clk)
    begin
        if (rst_n && !cmd_blocked)
        begin
            if (cmd_valid)
                send_gap <= gap_len();
            if ((!cmd_valid && send_gap > 0) || (cmd_valid && $urandom_range(0, 3) == 0)
                || pending_cmds.size() == 0)
            begin
                cmd_valid <= 1'b0;
                if (send_gap > 0 && !cmd_valid)
                    send_gap <= send_gap - 1;
            end
            else
            begin
                cmd_item_t it;
                it = pending_cmds.pop_front();
                cmd_valid   <= 1'b1;
                command     <= it.cmd;
                table_index <= it.idx;
                table_value <= it.val;
                x_coord     <= it.xc;
                y_coord     <= it.yc;
            end
        end
    end

    // receiver stalls
    int stall_gap;
    always @(negedge clk)
    begin
        if (!rst_n)
            noise_stall <= 1'b0;
        else if (hold_cycles > 0)
        begin
            noise_stall <= 1'b1;
            hold_cycles <= hold_cycles - 1;
        end
        else if (long_hold)
        begin
            noise_stall <= 1'b0;
            stall_gap   <= 0;
        end
        else if (stall_gap > 0)
        begin
            noise_stall <= 1'b1;
            stall_gap   <= stall_gap - 1;
        end
        else if (evals_sent > 600 && evals_sent < 1000 && $urandom_range(0, 4) == 0)
        begin
            noise_stall <= 1'b1;
            stall_gap   <= gap_len();
        end
        else
            noise_stall <= 1'b0;
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n && cmd_valid && !cmd_stall)
        begin
            if (command == CMD_LOAD)
            begin
                perm_copy[table_index] = table_value;
                loads_sent++;
            end
            else
            begin
                expected_noise.push_back(noise_at(x_coord, y_coord));
                evals_sent++;
            end
        end
        if (rst_n && noise_valid && !noise_stall)
        begin
            noise_seen++;
            if (expected_noise.size() == 0)
            begin
                $display("unexpected noise transfer %0d at %0t", noise_value, $time);
                mismatches++;
            end
            else
            begin
                logic signed [17:0] want;
                want = expected_noise.pop_front();
                if (noise_value !== want)
                    report_mismatch(noise_value, want);
            end
        end
    end

    initial
    begin
        #20_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        int k;
        logic [7:0] perm[256];
        mismatches  = 0;
        noise_seen  = 0;
        loads_sent  = 0;
        evals_sent  = 0;
        hold_cycles = 0;
        long_hold   = 1'b0;
        stim_done   = 1'b0;
        send_gap    = 0;
        stall_gap   = 0;
        rst_n       = 1'b0;
        cmd_valid   = 1'b0;
        noise_stall = 1'b0;
        command     = CMD_LOAD;
        table_index = '0;
        table_value = '0;
        x_coord     = '0;
        y_coord     = '0;

        // full table first: every entry written before any evaluate
        for (k = 0; k < 256; k++)
            perm[k] = 8'(k);
        for (k = 255; k > 0; k--)
        begin
            int j;
            logic [7:0] t;
            j = $urandom_range(0, k);
            t = perm[k]; perm[k] = perm[j]; perm[j] = t;
        end
        perm[0] = 8'hFF;
        perm[1] = 8'h00;
        for (k = 0; k < 256; k++)
            queue_load(8'(k), perm[k]);

        // directed corners and extremes
        queue_eval(24'h000000, 24'h000000);
        queue_eval(24'hFFFFFF, 24'hFFFFFF);
        queue_eval(24'h00FFFF, 24'h000000);
        queue_eval(24'h000000, 24'h00FFFF);
        queue_eval(24'h008000, 24'h008000);
        queue_eval(24'hFF8000, 24'h01FFFF);
        queue_eval(24'h00FFFF, 24'hFF0001);
        queue_eval(24'hAAAAAA, 24'h555555);
        queue_eval(24'h555555, 24'hAAAAAA);
        queue_load(8'd255, 8'd255);
        queue_load(8'd0, 8'd63);
        queue_eval(24'hFF0000, 24'hFF0000);
        queue_eval(24'h00C000, 24'h004000);

        for (k = 0; k < 1750; k++)
        begin
            if ($urandom_range(0, 9) == 0)
                queue_load(8'($urandom), 8'($urandom));
            else
                queue_eval(24'($urandom), 24'($urandom));
        end

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // long receiver hold-off while the sender keeps offering
        wait (evals_sent > 300);
        @(negedge clk);
        long_hold   = 1'b1;
        hold_cycles = 200;
        wait (hold_cycles == 0);
        @(negedge clk);
        long_hold = 1'b0;

        wait (pending_cmds.size() == 0 && !cmd_valid);
        @(posedge clk);
        stim_done = 1'b1;
        wait (expected_noise.size() == 0);
        repeat (LAT * 4) @(posedge clk);

        $display("covered %0d table writes and %0d noise evaluations, %0d results checked",
                 loads_sent, evals_sent, noise_seen);
        if (mismatches == 0 && expected_noise.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
